/* rtl/core/hhfe_pkg.sv */
// Shared types and constants for the HTTP header field extractor.
// Used by every module in rtl/core; no dependencies.
package hhfe_pkg;

  localparam int MAX_KEY_BYTES = 32;
  localparam int KEY_IDX_W     = $clog2(MAX_KEY_BYTES);
  localparam int KEY_POS_W     = $clog2(MAX_KEY_BYTES + 1);
  localparam int KEY_REG_BYTES = 8;
  localparam int KEY_REGS      = MAX_KEY_BYTES / KEY_REG_BYTES;
  localparam int KEY_W         = MAX_KEY_BYTES * 8;

  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_ADDR_W    = 6;
  localparam int CFG_DATA_W    = 64;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [2:0] {
    REG_KEY_0_7   = 3'd0,
    REG_KEY_8_15  = 3'd1,
    REG_KEY_16_23 = 3'd2,
    REG_KEY_24_31 = 3'd3,
    REG_KEY_LEN   = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_VALUE_BYTE = 2'd0,
    ST_VALUE_END  = 2'd1,
    ST_NOT_FOUND  = 2'd2,
    ST_INCOMPLETE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_NAME,
    PH_SKIP,
    PH_VALUE
  } phase_t;

  // classified request byte, as it travels through the queue
  typedef struct packed {
    logic [7:0] data;
    logic       eor;
    logic       is_cr;
    logic       is_lf;
    logic       is_colon;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

/* rtl/core/hhfe_front.sv */
// Front end: tags each request byte with its delimiter class.
// Depends on hhfe_pkg.
module hhfe_front (
  input  logic [7:0]    request_byte,
  input  logic          end_of_request,
  output hhfe_pkg::item_t item
);

  always_comb begin
    item.data     = request_byte;
    item.eor      = end_of_request;
    item.is_cr    = (request_byte == hhfe_pkg::CH_CR);
    item.is_lf    = (request_byte == hhfe_pkg::CH_LF);
    item.is_colon = (request_byte == hhfe_pkg::CH_COLON);
  end

endmodule

/* rtl/core/hhfe_queue.sv */
// Short register queue between classifier and scan engine.
// Depends on hhfe_pkg.
module hhfe_queue (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  hhfe_pkg::item_t                push_item,
  output logic                           full,
  input  logic                           pop,
  output hhfe_pkg::q_head_t              head,
  output logic [hhfe_pkg::QCNT_W-1:0]    count
);

  hhfe_pkg::item_t mem_r [hhfe_pkg::QUEUE_DEPTH];
  logic [hhfe_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [hhfe_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [hhfe_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic do_pop;

  assign full       = (count_r == hhfe_pkg::QCNT_W'(hhfe_pkg::QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.item  = mem_r[rd_ptr_r];
  assign count      = count_r;
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* rtl/core/hhfe_back.sv */
// Scan engine: header line state machine plus registered result slot.
// Depends on hhfe_pkg.
module hhfe_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hhfe_pkg::q_head_t                 head,
  output logic                              pop,
  input  logic [hhfe_pkg::KEY_W-1:0]        key,
  input  logic [5:0]                        key_length,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_value_byte,
  output hhfe_pkg::status_t                 out_status
);

  hhfe_pkg::phase_t                phase_r, phase_nxt;
  logic [hhfe_pkg::KEY_POS_W-1:0]  pos_r, pos_nxt;
  logic                            match_r, match_nxt;
  logic [1:0]                      tp_r, tp_nxt;
  logic                            fin_r, fin_nxt;

  logic                            valid_r, valid_nxt;
  logic [7:0]                      vbyte_r, vbyte_nxt;
  hhfe_pkg::status_t               status_r, status_nxt;

  logic [hhfe_pkg::KEY_POS_W-1:0]  klen;
  logic [7:0]                      key_byte;
  logic                            blank;
  logic                            have;
  logic [7:0]                      res_byte;
  hhfe_pkg::status_t               res_status;
  logic                            done;
  hhfe_pkg::item_t                 it;

  assign it  = head.item;
  assign pop = head.valid && (!valid_r || out_ready);

  assign klen = (key_length > 6'(hhfe_pkg::MAX_KEY_BYTES))
              ? hhfe_pkg::KEY_POS_W'(hhfe_pkg::MAX_KEY_BYTES)
              : hhfe_pkg::KEY_POS_W'(key_length);
  assign key_byte = key[pos_r[hhfe_pkg::KEY_IDX_W-1:0]*8 +: 8];

  // CR LF CR LF tracking
  always_comb begin
    blank = (tp_r == 2'd3) && it.is_lf;
    if (it.is_cr) begin
      tp_nxt = (tp_r == 2'd2) ? 2'd3 : 2'd1;
    end else if (it.is_lf) begin
      tp_nxt = (tp_r == 2'd1) ? 2'd2 : 2'd0;
    end else begin
      tp_nxt = 2'd0;
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    match_nxt = match_r;
    fin_nxt   = fin_r;
    if (!fin_r) begin
      if (blank) begin
        fin_nxt = 1'b1;
      end else begin
        case (phase_r)
          hhfe_pkg::PH_NAME: begin
            if (it.is_colon) begin
              phase_nxt = (match_r && pos_r >= klen) ? hhfe_pkg::PH_VALUE : hhfe_pkg::PH_SKIP;
            end else if (it.is_cr) begin
              phase_nxt = hhfe_pkg::PH_SKIP;
            end else if (pos_r < klen) begin
              if (it.data != key_byte) begin
                match_nxt = 1'b0;
              end
              pos_nxt = pos_r + 1'b1;
            end
          end
          hhfe_pkg::PH_SKIP: begin
            if (tp_nxt == 2'd2) begin
              phase_nxt = hhfe_pkg::PH_NAME;
              pos_nxt   = '0;
              match_nxt = 1'b1;
            end
          end
          hhfe_pkg::PH_VALUE: begin
            if (it.is_cr) begin
              fin_nxt = 1'b1;
            end
          end
          default: phase_nxt = hhfe_pkg::PH_NAME;
        endcase
      end
    end
    if (it.eor) begin
      phase_nxt = hhfe_pkg::PH_NAME;
      pos_nxt   = '0;
      match_nxt = 1'b1;
      fin_nxt   = 1'b0;
    end
  end

  // result of the current byte
  always_comb begin
    have       = 1'b0;
    res_byte   = '0;
    res_status = hhfe_pkg::ST_VALUE_BYTE;
    done       = fin_r || blank || (phase_r == hhfe_pkg::PH_VALUE && it.is_cr);
    if (!fin_r) begin
      if (blank) begin
        have       = 1'b1;
        res_status = hhfe_pkg::ST_NOT_FOUND;
      end else if (phase_r == hhfe_pkg::PH_VALUE) begin
        have = 1'b1;
        if (it.is_cr) begin
          res_status = hhfe_pkg::ST_VALUE_END;
        end else begin
          res_byte = it.data;
        end
      end
    end
    // open search at end of request overrides a value byte
    if (it.eor && !done) begin
      have       = 1'b1;
      res_byte   = '0;
      res_status = hhfe_pkg::ST_INCOMPLETE;
    end
  end

  always_comb begin
    valid_nxt  = valid_r;
    vbyte_nxt  = vbyte_r;
    status_nxt = status_r;
    if (pop && have) begin
      valid_nxt  = 1'b1;
      vbyte_nxt  = res_byte;
      status_nxt = res_status;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hhfe_pkg::PH_NAME;
      pos_r   <= '0;
      match_r <= 1'b1;
      tp_r    <= 2'd0;
      fin_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (pop) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        match_r <= match_nxt;
        fin_r   <= fin_nxt;
        tp_r    <= (it.eor || fin_r) ? 2'd0 : tp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    vbyte_r  <= vbyte_nxt;
    status_r <= status_nxt;
  end

  assign out_valid      = valid_r;
  assign out_value_byte = vbyte_r;
  assign out_status     = status_r;

endmodule

/* rtl/core/http_header_field_extractor.sv */
// HTTP header field extractor, top level: APB key registers, classifier, queue, scan engine.
// Accepted bytes are queued, then scanned; results are registered before out_tvalid.
// Throughput: one request byte per cycle unless output stalls fill the four-entry queue.
// Reset (synchronous, rst_n low): scan state, queue, result slot and key registers clear.
// Depends on hhfe_pkg, hhfe_front, hhfe_queue, hhfe_back.
module http_header_field_extractor (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] request_byte
  input  logic                               in_tlast,   // end_of_request
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [15:0]                        out_tdata,  // [7:0] value_byte, [9:8] status
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [hhfe_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [hhfe_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [hhfe_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  logic [hhfe_pkg::CFG_DATA_W-1:0] key_r [hhfe_pkg::KEY_REGS];
  logic [5:0]                      key_len_r;
  logic [hhfe_pkg::KEY_W-1:0]      key_flat;
  logic                            cfg_wr;
  hhfe_pkg::reg_idx_t              cfg_idx;

  hhfe_pkg::item_t                 fe_item;
  hhfe_pkg::q_head_t               q_head;
  logic                            q_full;
  logic                            q_pop;
  logic [hhfe_pkg::QCNT_W-1:0]     q_count;
  logic                            in_push;
  logic [7:0]                      res_byte;
  hhfe_pkg::status_t               res_status;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = hhfe_pkg::reg_idx_t'(cfg_paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < hhfe_pkg::KEY_REGS; i++) begin
        key_r[i] <= '0;
      end
      key_len_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        hhfe_pkg::REG_KEY_0_7:   key_r[0] <= cfg_pwdata;
        hhfe_pkg::REG_KEY_8_15:  key_r[1] <= cfg_pwdata;
        hhfe_pkg::REG_KEY_16_23: key_r[2] <= cfg_pwdata;
        hhfe_pkg::REG_KEY_24_31: key_r[3] <= cfg_pwdata;
        hhfe_pkg::REG_KEY_LEN:   key_len_r <= cfg_pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      hhfe_pkg::REG_KEY_0_7:   cfg_prdata = key_r[0];
      hhfe_pkg::REG_KEY_8_15:  cfg_prdata = key_r[1];
      hhfe_pkg::REG_KEY_16_23: cfg_prdata = key_r[2];
      hhfe_pkg::REG_KEY_24_31: cfg_prdata = key_r[3];
      hhfe_pkg::REG_KEY_LEN:   cfg_prdata = {{(hhfe_pkg::CFG_DATA_W-6){1'b0}}, key_len_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < hhfe_pkg::KEY_REGS; i++) begin
      key_flat[i*hhfe_pkg::CFG_DATA_W +: hhfe_pkg::CFG_DATA_W] = key_r[i];
    end
  end

  assign in_tready = !q_full;
  assign in_push   = in_tvalid && in_tready;

  hhfe_front u_front (
    .request_byte   (in_tdata),
    .end_of_request (in_tlast),
    .item           (fe_item)
  );

  hhfe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_item (fe_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .count     (q_count)
  );

  hhfe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .pop            (q_pop),
    .key            (key_flat),
    .key_length     (key_len_r),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_value_byte (res_byte),
    .out_status     (res_status)
  );

  assign out_tdata = {6'd0, res_status, res_byte};

  // scan engine only takes entries that exist
  a_pop_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.valid)
    else $error("pop from empty queue");

  // queue occupancy stays within its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= hhfe_pkg::QCNT_W'(hhfe_pkg::QUEUE_DEPTH))
    else $error("queue overflow");

  // status transactions carry a zero value byte
  a_status_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[9:8] != hhfe_pkg::ST_VALUE_BYTE) |-> out_tdata[7:0] == 8'd0)
    else $error("nonzero value byte on status");

  // no result leaves right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule
